// ----- rtl/core/cfac_pkg.sv -----
// shared types, codes and the byte-wide crc-16/modbus update
// used by the front, queue, back and top level of the crc16 framer
`timescale 1ns / 1ps

package cfac_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_APPEND_END,
    JOB_BYTE_VERDICT,
    JOB_VERDICT
  } job_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2
  } frame_status_t;

  typedef struct packed {
    job_kind_t     kind;
    logic [7:0]    data;
    logic [15:0]   crc;
    frame_status_t status;
  } job_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } queue_stat_t;

  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/cfac_front.sv -----
// front part: accepts bytes, keeps crc, hold and direction, emits at most one job per byte
// depends on cfac_pkg
`timescale 1ns / 1ps

module cfac_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr,
  input  logic          cfg_dir,
  output logic          dir,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          push,
  output cfac_pkg::job_t job
);
  import cfac_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  h0_r, h0_nxt, h1_r, h1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        dir_r, dir_nxt;
  logic [15:0] crc_in, crc_old_h0;
  logic [15:0] rx;

  assign dir        = dir_r;
  assign crc_in     = crc16_update(crc_r, data_byte);
  assign crc_old_h0 = crc16_update(crc_r, h0_r);

  always_comb begin
    crc_nxt = crc_r;
    h0_nxt  = h0_r;
    h1_nxt  = h1_r;
    cnt_nxt = cnt_r;
    dir_nxt = dir_r;
    push    = 1'b0;
    rx      = 16'h0000;
    job     = '{kind: JOB_PASS, data: data_byte, crc: crc_in, status: ST_OK};
    if (cfg_wr) begin
      dir_nxt = cfg_dir;
      crc_nxt = CRC_INIT;
      cnt_nxt = 2'd0;
    end else if (acc) begin
      if (!dir_r) begin
        push    = 1'b1;
        crc_nxt = crc_in;
        if (last_byte) begin
          job.kind = JOB_APPEND_END;
          crc_nxt  = CRC_INIT;
        end
      end else if (cnt_r == 2'd2) begin
        push     = 1'b1;
        job.data = h0_r;
        crc_nxt  = crc_old_h0;
        h0_nxt   = h1_r;
        h1_nxt   = data_byte;
        if (last_byte) begin
          rx         = {data_byte, h1_r};
          job.kind   = JOB_BYTE_VERDICT;
          job.status = (rx == crc_old_h0) ? ST_OK : ST_MISMATCH;
          crc_nxt    = CRC_INIT;
          cnt_nxt    = 2'd0;
        end
      end else begin
        if (cnt_r == 2'd0) begin
          h0_nxt = data_byte;
        end else begin
          h1_nxt = data_byte;
        end
        cnt_nxt = cnt_r + 2'd1;
        if (last_byte) begin
          push     = 1'b1;
          job.kind = JOB_VERDICT;
          job.data = 8'h00;
          rx       = {data_byte, h0_r};
          if (cnt_r == 2'd0) begin
            job.status = ST_SHORT;
          end else begin
            job.status = (rx == crc_r) ? ST_OK : ST_MISMATCH;
          end
          crc_nxt = CRC_INIT;
          cnt_nxt = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      h0_r  <= 8'h00;
      h1_r  <= 8'h00;
      cnt_r <= 2'd0;
      dir_r <= 1'b0;
    end else begin
      crc_r <= crc_nxt;
      h0_r  <= h0_nxt;
      h1_r  <= h1_nxt;
      cnt_r <= cnt_nxt;
      dir_r <= dir_nxt;
    end
  end

endmodule

// ----- rtl/core/cfac_queue.sv -----
// short job queue between front and back
// depends on cfac_pkg
`timescale 1ns / 1ps

module cfac_queue #(
  parameter int unsigned DEPTH = cfac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cfac_pkg::job_t      push_job,
  input  logic                pop,
  output cfac_pkg::job_t      head,
  output cfac_pkg::queue_stat_t stat
);
  import cfac_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/cfac_back.sv -----
// back part: expands each job into its result items into an output register
// depends on cfac_pkg
`timescale 1ns / 1ps

module cfac_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  cfac_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           byte_valid,
  output logic           frame_end,
  output logic [1:0]     frame_status,
  output logic           run_last
);
  import cfac_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       bv_r, bv_nxt, end_r, end_nxt, rl_r, rl_nxt;
  logic [1:0] st_r, st_nxt;
  logic       load, final_item;

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign byte_valid   = bv_r;
  assign frame_end    = end_r;
  assign frame_status = st_r;
  assign run_last     = rl_r;
  assign load         = !valid_r || out_ready;

  always_comb begin
    byte_nxt   = job.data;
    bv_nxt     = 1'b1;
    end_nxt    = 1'b0;
    st_nxt     = ST_OK;
    rl_nxt     = 1'b0;
    final_item = 1'b0;
    unique case (job.kind)
      JOB_PASS: begin
        rl_nxt     = 1'b1;
        final_item = 1'b1;
      end
      JOB_APPEND_END: begin
        if (idx_r == 2'd1) begin
          byte_nxt = job.crc[7:0];
        end else if (idx_r == 2'd2) begin
          byte_nxt   = job.crc[15:8];
          end_nxt    = 1'b1;
          rl_nxt     = 1'b1;
          final_item = 1'b1;
        end
      end
      JOB_BYTE_VERDICT: begin
        if (idx_r != 2'd0) begin
          byte_nxt   = 8'h00;
          bv_nxt     = 1'b0;
          end_nxt    = 1'b1;
          st_nxt     = job.status;
          rl_nxt     = 1'b1;
          final_item = 1'b1;
        end
      end
      JOB_VERDICT: begin
        byte_nxt   = 8'h00;
        bv_nxt     = 1'b0;
        end_nxt    = 1'b1;
        st_nxt     = job.status;
        rl_nxt     = 1'b1;
        final_item = 1'b1;
      end
      default: begin
        final_item = 1'b1;
      end
    endcase
    pop       = load && job_valid && final_item;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = job_valid;
      if (job_valid) begin
        idx_nxt = final_item ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      byte_r <= byte_nxt;
      bv_r   <= bv_nxt;
      end_r  <= end_nxt;
      st_r   <= st_nxt;
      rl_r   <= rl_nxt;
    end
  end

endmodule

// ----- rtl/core/crc16_frame_append_check.sv -----
// top level of the crc-16/modbus frame appender and checker
// depends on cfac_pkg, cfac_front, cfac_queue, cfac_back
`timescale 1ns / 1ps

// Byte stream framer with CRC-16/MODBUS (reflected 0xA001, init 0xFFFF, no final xor).
// Register 0 (direction) at address 0: 0 appends the crc after the last byte, low
// byte first; 1 holds bytes back two places, strips the trailing crc and issues a
// verdict item (tlast, status in tuser) after the frame's data: ok, mismatch or too
// short. Writing direction drops any frame in progress. One input byte is taken
// every cycle while the job queue (QUEUE_DEPTH entries) has room; the output side
// delivers one item a cycle while out_tready is high, so a pass-through byte yields one
// item, an append frame end three and a check frame end two, or one when the frame holds
// fewer than three bytes; the first two bytes of a check frame yield no item of their own.
// The output register drain rate is what limits sustained throughput on frames
// with many ends.
module crc16_frame_append_check #(
  parameter int unsigned QUEUE_DEPTH = cfac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] run_last, [15:9] zero
  output logic [2:0]  out_tuser,  // [0] byte_valid, [2:1] frame_status
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cfac_pkg::*;

  logic        cfg_wr, dir, acc, push, pop;
  job_t        push_job, head;
  queue_stat_t qstat;
  logic [7:0]  o_byte;
  logic        o_bv, o_end, o_rl;
  logic [1:0]  o_st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {31'd0, dir} : 32'd0;
  assign in_tready  = !qstat.full;
  assign acc        = in_tvalid && in_tready;

  cfac_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_dir   (cfg_pwdata[0]),
    .dir       (dir),
    .acc       (acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push),
    .job       (push_job)
  );

  cfac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  cfac_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (!qstat.empty),
    .job          (head),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (o_byte),
    .byte_valid   (o_bv),
    .frame_end    (o_end),
    .frame_status (o_st),
    .run_last     (o_rl)
  );

  assign out_tdata = {7'd0, o_rl, o_byte};
  assign out_tuser = {o_st, o_bv};
  assign out_tlast = o_end;

  // a job is never offered to a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("job pushed into full queue");

  // a nonzero status only rides on a frame end item
  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != 2'd0) |-> out_tlast && !out_tuser[0])
    else $error("frame status outside verdict item");

  // an item without a byte is always a verdict closing its run
  a_verdict_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata[8] && (out_tdata[7:0] == 8'h00))
    else $error("malformed verdict item");

endmodule
